FILE: hdl/tpv_pkg.sv
// ============================================================================
// tpv_pkg
// Shared types, constants and arithmetic helpers for the TPV distortion
// polynomial pipeline.
// ============================================================================
package tpv_pkg;

    localparam int MAX_TERMS       = 40;
    localparam int MAX_SLOTS       = 8;
    localparam int NUM_TERMS_DEF   = 40;
    localparam int POWER_SLOTS_DEF = 8;
    localparam int FRAC_BITS_DEF   = 28;

    // stage 0 capture, stage 1 squares, stages 2..17 root, 18 clip, 19..24 r powers
    localparam int PIPE_DEPTH  = 25;
    localparam int ROOT_FIRST  = 2;
    localparam int ROOT_LAST   = 17;
    localparam int ROOT_CLIP   = 18;
    localparam int RPOW_FIRST  = 19;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic signed [63:0] W32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] W32_MIN = -64'sh0000_0000_8000_0000;

    localparam logic [2:0] EXP_A [MAX_TERMS] = '{
        3'd0, 3'd1, 3'd0, 3'd0, 3'd2, 3'd1, 3'd0, 3'd3, 3'd2, 3'd1,
        3'd0, 3'd0, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd5, 3'd4, 3'd3,
        3'd2, 3'd1, 3'd0, 3'd0, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1,
        3'd0, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd0};
    localparam logic [2:0] EXP_B [MAX_TERMS] = '{
        3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2,
        3'd3, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2,
        3'd3, 3'd4, 3'd5, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
        3'd6, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0};
    localparam logic [2:0] EXP_R [MAX_TERMS] = '{
        3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd7};

    // powers 1..7 of u (xi side), w (eta side) and r, with clip marks
    typedef struct packed {
        logic [MAX_SLOTS-1:1][31:0] xp;
        logic [MAX_SLOTS-1:1][31:0] yp;
        logic [MAX_SLOTS-1:1][31:0] rp;
        logic [MAX_SLOTS-1:1]       xs;
        logic [MAX_SLOTS-1:1]       ys;
        logic [MAX_SLOTS-1:1]       rs;
    } tpv_pow_t;

    typedef struct packed {
        logic        valid;
        logic        func;
        logic        axis;
        logic [5:0]  idx;
        logic [31:0] coef;
    } tpv_ctl_t;

    typedef struct packed {
        tpv_ctl_t    ctl;
        logic [63:0] pa;     // x*x, then root remainder
        logic [63:0] pb;     // y*y, then root
        tpv_pow_t    pw;
    } tpv_stage_t;

    typedef struct packed {
        logic        we;
        logic [5:0]  idx;
        logic [31:0] value;
    } tpv_load_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] res;
    } tpv_sq_t;

    function automatic logic signed [63:0] mul32(logic [31:0] a, logic [31:0] b);
        logic signed [63:0] ea;
        logic signed [63:0] eb;
        ea = 64'(signed'(a));
        eb = 64'(signed'(b));
        return ea * eb;
    endfunction

    // round half up, then floor shift
    function automatic logic signed [63:0] rnd(logic signed [63:0] v, int frac);
        logic signed [63:0] t;
        t = v + (64'sd1 <<< (frac - 1));
        return t >>> frac;
    endfunction

    function automatic logic [31:0] sat32(logic signed [63:0] v);
        logic [31:0] r;
        if (v > W32_MAX) r = 32'h7FFF_FFFF;
        else if (v < W32_MIN) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic ovf32(logic signed [63:0] v);
        return (v > W32_MAX) || (v < W32_MIN);
    endfunction

    function automatic tpv_sq_t sqrt_step(tpv_sq_t s, logic [63:0] b);
        tpv_sq_t o;
        o = s;
        if (s.rem >= s.res + b) begin
            o.rem = s.rem - (s.res + b);
            o.res = (s.res >> 1) + b;
        end else begin
            o.res = s.res >> 1;
        end
        return o;
    endfunction

endpackage

FILE: hdl/tpv_axis.sv
// ============================================================================
// tpv_axis
// One output axis: coefficient registers, monomials, coefficient products,
// grouped partial sums and the saturated final sum.
// ============================================================================
module tpv_axis #(
    parameter int NUM_TERMS   = tpv_pkg::NUM_TERMS_DEF,
    parameter int POWER_SLOTS = tpv_pkg::POWER_SLOTS_DEF,
    parameter int FRAC_BITS   = tpv_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  tpv_pkg::tpv_pow_t pw,
    input  tpv_pkg::tpv_load_t ld,
    output logic [31:0]       res_out,
    output logic              res_flag
);

    localparam int NGRP = (NUM_TERMS + 7) / 8;
    localparam logic [31:0] ONE = (FRAC_BITS >= 31) ? 32'h7FFF_FFFF
                                                    : 32'(64'd1 << FRAC_BITS);

    logic [31:0]        coef_reg [NUM_TERMS];
    logic [31:0]        mono_reg [NUM_TERMS];
    logic [31:0]        mono_next [NUM_TERMS];
    logic               msat_reg [NUM_TERMS];
    logic               msat_next [NUM_TERMS];
    logic signed [63:0] term_reg [NUM_TERMS];
    logic signed [63:0] term_next [NUM_TERMS];
    logic [NUM_TERMS-1:0] tflag;
    logic               flag26_reg;
    logic signed [63:0] psum_reg [NGRP];
    logic signed [63:0] psum_next [NGRP];
    logic               flag27_reg;
    logic signed [63:0] total;
    logic [31:0]        res_reg;
    logic               flag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < NUM_TERMS; t++) begin
                coef_reg[t] <= (t == 1) ? ONE : 32'd0;
            end
        end else if (ld.we) begin
            for (int t = 0; t < NUM_TERMS; t++) begin
                if (ld.idx == 6'(t)) coef_reg[t] <= ld.value;
            end
        end
    end

    for (genvar t = 0; t < NUM_TERMS; t++) begin : g_term
        localparam int A = int'(tpv_pkg::EXP_A[t]);
        localparam int B = int'(tpv_pkg::EXP_B[t]);
        localparam int C = int'(tpv_pkg::EXP_R[t]);
        localparam bit SKIP = (A >= POWER_SLOTS) || (B >= POWER_SLOTS) ||
                              (C >= POWER_SLOTS);
        localparam bit CONST = (A == 0) && (B == 0) && (C == 0);

        if (SKIP || CONST) begin : g_none
            assign mono_next[t] = 32'd0;
            assign msat_next[t] = 1'b0;
        end else if (C > 0) begin : g_r
            assign mono_next[t] = pw.rp[C];
            assign msat_next[t] = pw.rs[C];
        end else if (B == 0) begin : g_u
            assign mono_next[t] = pw.xp[A];
            assign msat_next[t] = pw.xs[A];
        end else if (A == 0) begin : g_w
            assign mono_next[t] = pw.yp[B];
            assign msat_next[t] = pw.ys[B];
        end else begin : g_mix
            logic signed [63:0] mr;
            assign mr = tpv_pkg::rnd(tpv_pkg::mul32(pw.xp[A], pw.yp[B]), FRAC_BITS);
            assign mono_next[t] = tpv_pkg::sat32(mr);
            assign msat_next[t] = pw.xs[A] | pw.ys[B] | tpv_pkg::ovf32(mr);
        end

        if (SKIP) begin : g_tz
            assign term_next[t] = 64'sd0;
            assign tflag[t]     = 1'b0;
        end else if (CONST) begin : g_tc
            assign term_next[t] = 64'(signed'(coef_reg[t]));
            assign tflag[t]     = 1'b0;
        end else begin : g_tm
            assign term_next[t] = tpv_pkg::rnd(tpv_pkg::mul32(coef_reg[t], mono_reg[t]),
                                               FRAC_BITS);
            assign tflag[t]     = (coef_reg[t] != 32'd0) && msat_reg[t];
        end
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            psum_next[g] = 64'sd0;
            for (int j = 0; j < 8; j++) begin
                if (g * 8 + j < NUM_TERMS) psum_next[g] = psum_next[g] + term_reg[g * 8 + j];
            end
        end
    end

    always_comb begin
        total = 64'sd0;
        for (int g = 0; g < NGRP; g++) total = total + psum_reg[g];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mono_reg   <= mono_next;
            msat_reg   <= msat_next;
            term_reg   <= term_next;
            flag26_reg <= |tflag;
            psum_reg   <= psum_next;
            flag27_reg <= flag26_reg;
            res_reg    <= tpv_pkg::sat32(total);
            flag_reg   <= flag27_reg | tpv_pkg::ovf32(total);
        end
    end

    assign res_out  = res_reg;
    assign res_flag = flag_reg;

endmodule

FILE: hdl/tpv_distortion_polynomial_top.sv
// ============================================================================
// tpv_distortion_polynomial_top
// TPV order-7 distortion polynomial over signed fixed-point coordinates.
// ============================================================================
// Usage:
//   Input items arrive on s_tvalid/s_tready. s_tuser selects the operation:
//   a load writes one coefficient (table from coef_axis, term coef_index,
//   indices beyond the table are dropped) and returns nothing; an evaluate
//   item returns one result item on m_tvalid/m_tready with xi', eta' and
//   the saturation flag in m_tuser.
//   Throughput: one item per cycle while m_tready does not hold the
//   pipeline. Items pass through the capture and squares stages, the
//   16-stage two-bits-per-stage square root, the clip stage, the six-stage
//   chain of r powers and the monomial, product and two summing stages.
//   Loads travel down the pipeline and take effect at the product stage,
//   so items keep their order against coefficient changes.
//   Reset clears all valid bits and returns both tables to identity
//   (term one holds 1.0).
//   When m_tready is low with a result waiting, the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated.
// ============================================================================
module tpv_distortion_polynomial_top #(
    parameter int NUM_TERMS   = tpv_pkg::NUM_TERMS_DEF,
    parameter int POWER_SLOTS = tpv_pkg::POWER_SLOTS_DEF,
    parameter int FRAC_BITS   = tpv_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // coef_axis[0], coef_index[6:1], coef_value[38:7], xi_in[70:39], eta_in[102:71]
    input  logic [103:0] s_tdata,
    // func[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // xi_out[31:0], eta_out[63:32]
    output logic [63:0]  m_tdata,
    // saturated[0]
    output logic [0:0]   m_tuser
);

    localparam int PD = tpv_pkg::PIPE_DEPTH;

    tpv_pkg::tpv_stage_t pipe_reg  [PD];
    tpv_pkg::tpv_stage_t pipe_next [PD];
    tpv_pkg::tpv_ctl_t   ctl25_reg, ctl26_reg, ctl27_reg;
    tpv_pkg::tpv_pow_t   pw_x, pw_y;
    tpv_pkg::tpv_load_t  ld_x, ld_y;
    logic                out_valid_reg;
    logic                en;
    logic [31:0]         xi_res, eta_res;
    logic                xi_flag, eta_flag;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_comb begin
        pipe_next[0]          = '0;
        pipe_next[0].ctl.valid = s_tvalid;
        pipe_next[0].ctl.func  = s_tuser[0];
        pipe_next[0].ctl.axis  = s_tdata[0];
        pipe_next[0].ctl.idx   = s_tdata[6:1];
        pipe_next[0].ctl.coef  = s_tdata[38:7];
        pipe_next[0].pw.xp[1]  = s_tdata[70:39];
        pipe_next[0].pw.yp[1]  = s_tdata[102:71];
        pipe_next[0].pa        = tpv_pkg::mul32(s_tdata[70:39], s_tdata[70:39]);
        pipe_next[0].pb        = tpv_pkg::mul32(s_tdata[102:71], s_tdata[102:71]);
    end

    for (genvar i = 1; i < PD; i++) begin : g_stage
        if (i == 1) begin : g_sq
            always_comb begin
                pipe_next[i] = pipe_reg[i-1];
                pipe_next[i].pa = pipe_reg[i-1].pa + pipe_reg[i-1].pb;
                pipe_next[i].pb = 64'd0;
                if (POWER_SLOTS > 2) begin
                    pipe_next[i].pw.xp[2] = tpv_pkg::sat32(
                        tpv_pkg::rnd(signed'(pipe_reg[i-1].pa), FRAC_BITS));
                    pipe_next[i].pw.yp[2] = tpv_pkg::sat32(
                        tpv_pkg::rnd(signed'(pipe_reg[i-1].pb), FRAC_BITS));
                    pipe_next[i].pw.xs[2] = tpv_pkg::ovf32(
                        tpv_pkg::rnd(signed'(pipe_reg[i-1].pa), FRAC_BITS));
                    pipe_next[i].pw.ys[2] = tpv_pkg::ovf32(
                        tpv_pkg::rnd(signed'(pipe_reg[i-1].pb), FRAC_BITS));
                end
            end
        end else if (i <= tpv_pkg::ROOT_LAST) begin : g_root
            localparam int J = 4 * (i - tpv_pkg::ROOT_FIRST);
            localparam int K = (i + 1 < tpv_pkg::MAX_SLOTS) ? i + 1 : tpv_pkg::MAX_SLOTS - 1;
            localparam bit DO_POW = (i + 1 < POWER_SLOTS);
            tpv_pkg::tpv_sq_t  s0, s1, s2;
            logic signed [63:0] px, py;
            always_comb begin
                pipe_next[i] = pipe_reg[i-1];
                s0.rem = pipe_reg[i-1].pa;
                s0.res = pipe_reg[i-1].pb;
                s1 = tpv_pkg::sqrt_step(s0, 64'd1 << (62 - J));
                s2 = tpv_pkg::sqrt_step(s1, 64'd1 << (60 - J));
                pipe_next[i].pa = s2.rem;
                pipe_next[i].pb = s2.res;
                px = tpv_pkg::rnd(tpv_pkg::mul32(pipe_reg[i-1].pw.xp[K-1],
                                                 pipe_reg[i-1].pw.xp[1]), FRAC_BITS);
                py = tpv_pkg::rnd(tpv_pkg::mul32(pipe_reg[i-1].pw.yp[K-1],
                                                 pipe_reg[i-1].pw.yp[1]), FRAC_BITS);
                if (DO_POW) begin
                    pipe_next[i].pw.xp[K] = tpv_pkg::sat32(px);
                    pipe_next[i].pw.yp[K] = tpv_pkg::sat32(py);
                    pipe_next[i].pw.xs[K] = pipe_reg[i-1].pw.xs[K-1] | tpv_pkg::ovf32(px);
                    pipe_next[i].pw.ys[K] = pipe_reg[i-1].pw.ys[K-1] | tpv_pkg::ovf32(py);
                end
            end
        end else if (i == tpv_pkg::ROOT_CLIP) begin : g_clip
            always_comb begin
                pipe_next[i] = pipe_reg[i-1];
                pipe_next[i].pw.rp[1] = tpv_pkg::sat32(signed'(pipe_reg[i-1].pb));
                pipe_next[i].pw.rs[1] = tpv_pkg::ovf32(signed'(pipe_reg[i-1].pb));
            end
        end else begin : g_rpow
            localparam int K = i - tpv_pkg::RPOW_FIRST + 2;
            logic signed [63:0] pr;
            always_comb begin
                pipe_next[i] = pipe_reg[i-1];
                pr = tpv_pkg::rnd(tpv_pkg::mul32(pipe_reg[i-1].pw.rp[K-1],
                                                 pipe_reg[i-1].pw.rp[1]), FRAC_BITS);
                if (K < POWER_SLOTS) begin
                    pipe_next[i].pw.rp[K] = tpv_pkg::sat32(pr);
                    pipe_next[i].pw.rs[K] = pipe_reg[i-1].pw.rs[K-1] | tpv_pkg::ovf32(pr);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PD; i++) pipe_reg[i].ctl.valid <= 1'b0;
            ctl25_reg.valid <= 1'b0;
            ctl26_reg.valid <= 1'b0;
            ctl27_reg.valid <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else if (en) begin
            pipe_reg      <= pipe_next;
            ctl25_reg     <= pipe_reg[PD-1].ctl;
            ctl26_reg     <= ctl25_reg;
            ctl27_reg     <= ctl26_reg;
            out_valid_reg <= ctl27_reg.valid && (ctl27_reg.func == tpv_pkg::FUNC_EVAL);
        end
    end

    // eta' uses the same terms with xi and eta exchanged
    always_comb begin
        pw_x    = pipe_reg[PD-1].pw;
        pw_y    = pipe_reg[PD-1].pw;
        pw_y.xp = pipe_reg[PD-1].pw.yp;
        pw_y.xs = pipe_reg[PD-1].pw.ys;
        pw_y.yp = pipe_reg[PD-1].pw.xp;
        pw_y.ys = pipe_reg[PD-1].pw.xs;
    end

    always_comb begin
        ld_x.we    = en && ctl25_reg.valid && (ctl25_reg.func == tpv_pkg::FUNC_LOAD) &&
                     !ctl25_reg.axis;
        ld_x.idx   = ctl25_reg.idx;
        ld_x.value = ctl25_reg.coef;
        ld_y       = ld_x;
        ld_y.we    = en && ctl25_reg.valid && (ctl25_reg.func == tpv_pkg::FUNC_LOAD) &&
                     ctl25_reg.axis;
    end

    tpv_axis #(
        .NUM_TERMS(NUM_TERMS), .POWER_SLOTS(POWER_SLOTS), .FRAC_BITS(FRAC_BITS)
    ) u_axis_xi (
        .aclk(aclk), .aresetn(aresetn), .en(en), .pw(pw_x), .ld(ld_x),
        .res_out(xi_res), .res_flag(xi_flag)
    );

    tpv_axis #(
        .NUM_TERMS(NUM_TERMS), .POWER_SLOTS(POWER_SLOTS), .FRAC_BITS(FRAC_BITS)
    ) u_axis_eta (
        .aclk(aclk), .aresetn(aresetn), .en(en), .pw(pw_y), .ld(ld_y),
        .res_out(eta_res), .res_flag(eta_flag)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {eta_res, xi_res};
    assign m_tuser  = xi_flag | eta_flag;

endmodule
